/* rtl/rtsm_pkg.sv */
// shared constants, codes and types of the ratio test stereo matcher
`default_nettype none
package rtsm_pkg;

	localparam int RIGHT_ENTRIES = 1024;
	localparam int LEFT_ENTRIES  = 4096;

	localparam int CMD_W   = 3;
	localparam int LEFT_W  = 12;
	localparam int RIGHT_W = 10;
	localparam int DIST_W  = 9;
	localparam int CFG_W   = 9;
	localparam int CFG_IDX_W = 2;

	localparam int RIDX_W  = $clog2(RIGHT_ENTRIES);
	localparam int LIDX_W  = $clog2(LEFT_ENTRIES);
	localparam int EPOCH_W = 8;
	localparam int PROD_W  = 2 * CFG_W;

	localparam logic [DIST_W-1:0]  NONE_DIST = '1;
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
	localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;
	localparam logic [EPOCH_W-1:0] EPOCH_STALE = '0;

	localparam logic [CFG_W-1:0] MAX_BEST_RESET = CFG_W'(60);
	localparam logic [CFG_W-1:0] BYPASS_RESET   = CFG_W'(80);
	localparam logic [CFG_W-1:0] RATIO_RESET    = CFG_W'(218);

	typedef enum logic [CMD_W-1:0] {
		CMD_CANDIDATE = 3'd0,
		CMD_DECIDE    = 3'd1,
		CMD_COMMIT    = 3'd2,
		CMD_QUERY     = 3'd3,
		CMD_CLEAR     = 3'd4
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_BEST = 2'd0,
		REG_BYPASS   = 2'd1,
		REG_RATIO    = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0] max_best;
		logic [CFG_W-1:0] bypass;
		logic [CFG_W-1:0] ratio;
	} cfg_t;

	typedef struct packed {
		logic               candidate;
		logic               decide;
		logic [RIGHT_W-1:0] right;
		logic [DIST_W-1:0]  distance;
	} acc_req_t;

	typedef struct packed {
		logic               accepted;
		logic [RIGHT_W-1:0] matched_right;
		logic [DIST_W-1:0]  best;
		logic [DIST_W-1:0]  second;
	} decide_t;

	typedef struct packed {
		logic              commit;
		logic              query;
		logic              clear;
		logic [RIDX_W-1:0] addr;
		logic [LIDX_W-1:0] owner;
		logic [DIST_W-1:0] distance;
	} tbl_req_t;

	typedef struct packed {
		logic [EPOCH_W-1:0] tag;
		logic [LIDX_W-1:0]  owner;
		logic [DIST_W-1:0]  distance;
	} tbl_entry_t;

endpackage
`default_nettype wire

/* rtl/rtsm_if.sv */
// request and result channel interfaces
`default_nettype none
interface rtsm_in_if;
	import rtsm_pkg::*;
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [LEFT_W-1:0]  left_index;
	logic [RIGHT_W-1:0] right_index;
	logic [DIST_W-1:0]  distance;
	logic               pair_ok;

	modport source (output valid, command, left_index, right_index, distance, pair_ok,
		input ready);
	modport sink (input valid, command, left_index, right_index, distance, pair_ok,
		output ready);
endinterface

interface rtsm_out_if;
	import rtsm_pkg::*;
	logic               valid;
	logic               ready;
	logic               accepted;
	logic [RIGHT_W-1:0] matched_right;
	logic [DIST_W-1:0]  best_distance;
	logic [DIST_W-1:0]  second_distance;
	logic               entry_kept;
	logic               is_current;

	modport source (output valid, accepted, matched_right, best_distance, second_distance,
		entry_kept, is_current, input ready);
	modport sink (input valid, accepted, matched_right, best_distance, second_distance,
		entry_kept, is_current, output ready);
endinterface
`default_nettype wire

/* rtl/rtsm_accum.sv */
// best and second-best accumulator with the ratio test
`default_nettype none
module rtsm_accum (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              upd,
	input  wire rtsm_pkg::acc_req_t req,
	input  wire rtsm_pkg::cfg_t    cfg,
	output rtsm_pkg::decide_t      res
);
	import rtsm_pkg::*;

	logic [DIST_W-1:0]  best_q;
	logic [DIST_W-1:0]  second_q;
	logic [RIGHT_W-1:0] best_idx_q;
	logic               found_q;
	logic [PROD_W-1:0]  prod;
	logic               ratio_ok;

	always_comb begin
		prod     = cfg.ratio * second_q;
		ratio_ok = (second_q >= cfg.bypass) ||
			(PROD_W'(best_q) <= (prod >> 8));
		res.accepted      = found_q && (best_q <= cfg.max_best) && ratio_ok;
		res.matched_right = best_idx_q;
		res.best          = best_q;
		res.second        = second_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q     <= NONE_DIST;
			second_q   <= NONE_DIST;
			best_idx_q <= '0;
			found_q    <= 1'b0;
		end else if (upd) begin
			if (req.decide) begin
				best_q     <= NONE_DIST;
				second_q   <= NONE_DIST;
				best_idx_q <= '0;
				found_q    <= 1'b0;
			end else if (req.candidate) begin
				if (req.distance < best_q) begin
					second_q   <= best_q;
					best_q     <= req.distance;
					best_idx_q <= req.right;
					found_q    <= 1'b1;
				end else if (req.distance < second_q) begin
					second_q <= req.distance;
				end
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/rtsm_table.sv */
// per-right ownership table with epoch tags and a clearing sweep
`default_nettype none
module rtsm_table (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    acc,
	input  wire logic [rtsm_pkg::RIDX_W-1:0] acc_addr,
	input  wire rtsm_pkg::tbl_req_t      req,
	input  wire logic                    advance,
	output logic                         kept,
	output logic                         current,
	output logic                         busy
);
	import rtsm_pkg::*;

	tbl_entry_t         mem_q [RIGHT_ENTRIES];
	tbl_entry_t         rd_q;
	tbl_entry_t         byp_q;
	logic               byp_hit_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic               sweep_q;
	logic [RIDX_W-1:0]  sweep_cnt_q;

	tbl_entry_t         entry;
	logic               entry_valid;
	logic               wr_en;
	logic [RIDX_W-1:0]  wr_addr;
	tbl_entry_t         wr_data;

	always_comb begin
		entry       = byp_hit_q ? byp_q : rd_q;
		entry_valid = (entry.tag == epoch_q);
		kept        = req.commit && (!entry_valid || (req.distance < entry.distance));
		current     = req.query && entry_valid && (entry.owner == req.owner);
		busy        = sweep_q || (req.clear && (epoch_q == EPOCH_LAST));

		if (sweep_q) begin
			wr_en            = 1'b1;
			wr_addr          = sweep_cnt_q;
			wr_data.tag      = EPOCH_STALE;
			wr_data.owner    = '0;
			wr_data.distance = '0;
		end else begin
			wr_en            = advance && kept;
			wr_addr          = req.addr;
			wr_data.tag      = epoch_q;
			wr_data.owner    = req.owner;
			wr_data.distance = req.distance;
		end
	end

	// memory: one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (acc) begin
			rd_q  <= mem_q[acc_addr];
			byp_q <= wr_data;
		end
	end

	// write of the leaving item to the address being read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_hit_q <= 1'b0;
		end else if (acc) begin
			byp_hit_q <= wr_en && (wr_addr == acc_addr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q     <= EPOCH_FIRST;
			sweep_q     <= 1'b1;
			sweep_cnt_q <= '0;
		end else if (sweep_q) begin
			sweep_cnt_q <= sweep_cnt_q + RIDX_W'(1);
			if (sweep_cnt_q == RIDX_W'(RIGHT_ENTRIES - 1)) begin
				sweep_q <= 1'b0;
			end
		end else if (advance && req.clear) begin
			if (epoch_q == EPOCH_LAST) begin
				epoch_q     <= EPOCH_FIRST;
				sweep_q     <= 1'b1;
				sweep_cnt_q <= '0;
			end else begin
				epoch_q <= epoch_q + EPOCH_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/ratio_test_stereo_matcher.sv */
// top level of the ratio test stereo matcher
`default_nettype none
// Takes one request per cycle on cmd, unless the result side or a sweep holds
// it, and returns results on res, one for each decide, commit and query
// request, none for candidate, clear or unknown codes. A request is registered
// with the table read, evaluated in one stage, and its result is held in an
// output register, so back-to-back requests run at one per cycle while the
// result side keeps up. The right-side table is a 1024-entry single-port-write
// memory whose entries are tagged with a clear epoch, so a clear only advances
// the epoch; after reset, and after every 255th clear once the epoch counter
// wraps, the table is swept in full while cmd is not ready. Configuration
// writes are taken at any time but must only be made while the block is idle.
module ratio_test_stereo_matcher (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [rtsm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rtsm_pkg::CFG_W-1:0]   cfg_data,
	rtsm_in_if.sink                           cmd,
	rtsm_out_if.source                        res
);
	import rtsm_pkg::*;

	cfg_t               cfg_q;

	logic               valid_s1;
	logic [CMD_W-1:0]   cmd_s1;
	logic [LEFT_W-1:0]  left_s1;
	logic [RIGHT_W-1:0] right_s1;
	logic [DIST_W-1:0]  dist_s1;
	logic               ok_s1;

	logic               out_valid_q;
	logic               accepted_q;
	logic [RIGHT_W-1:0] matched_right_q;
	logic [DIST_W-1:0]  best_q;
	logic [DIST_W-1:0]  second_q;
	logic               kept_q;
	logic               current_q;

	logic               acc;
	logic               has_result;
	logic               advance;
	logic               in_range;
	acc_req_t           acc_req;
	decide_t            decide_res;
	tbl_req_t           tbl_req;
	logic               tbl_kept;
	logic               tbl_current;
	logic               tbl_busy;

	always_comb begin
		has_result = valid_s1 && ((cmd_s1 == CMD_DECIDE) || (cmd_s1 == CMD_COMMIT) ||
			(cmd_s1 == CMD_QUERY));
		advance    = valid_s1 && (!has_result || !out_valid_q || res.ready);
		cmd.ready  = (!valid_s1 || advance) && !tbl_busy;
		acc        = cmd.valid && cmd.ready;
		in_range   = (32'(right_s1) < RIGHT_ENTRIES) && (32'(left_s1) < LEFT_ENTRIES);

		acc_req.candidate = valid_s1 && (cmd_s1 == CMD_CANDIDATE) && ok_s1;
		acc_req.decide    = valid_s1 && (cmd_s1 == CMD_DECIDE);
		acc_req.right     = right_s1;
		acc_req.distance  = dist_s1;

		tbl_req.commit   = valid_s1 && (cmd_s1 == CMD_COMMIT) && in_range;
		tbl_req.query    = valid_s1 && (cmd_s1 == CMD_QUERY) && in_range;
		tbl_req.clear    = valid_s1 && (cmd_s1 == CMD_CLEAR);
		tbl_req.addr     = RIDX_W'(right_s1);
		tbl_req.owner    = LIDX_W'(left_s1);
		tbl_req.distance = dist_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_best <= MAX_BEST_RESET;
			cfg_q.bypass   <= BYPASS_RESET;
			cfg_q.ratio    <= RATIO_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_BEST: cfg_q.max_best <= cfg_data;
				REG_BYPASS:   cfg_q.bypass   <= cfg_data;
				REG_RATIO:    cfg_q.ratio    <= cfg_data;
				default: ;
			endcase
		end
	end

	// request stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_s1   <= cmd.command;
			left_s1  <= cmd.left_index;
			right_s1 <= cmd.right_index;
			dist_s1  <= cmd.distance;
			ok_s1    <= cmd.pair_ok;
		end
	end

	rtsm_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (advance),
		.req    (acc_req),
		.cfg    (cfg_q),
		.res    (decide_res)
	);

	rtsm_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.acc_addr (RIDX_W'(cmd.right_index)),
		.req      (tbl_req),
		.advance  (advance),
		.kept     (tbl_kept),
		.current  (tbl_current),
		.busy     (tbl_busy)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			accepted_q      <= acc_req.decide && decide_res.accepted;
			matched_right_q <= acc_req.decide ? decide_res.matched_right : '0;
			best_q          <= acc_req.decide ? decide_res.best : '0;
			second_q        <= acc_req.decide ? decide_res.second : '0;
			kept_q          <= tbl_kept;
			current_q       <= tbl_current;
		end
	end

	assign res.valid           = out_valid_q;
	assign res.accepted        = accepted_q;
	assign res.matched_right   = matched_right_q;
	assign res.best_distance   = best_q;
	assign res.second_distance = second_q;
	assign res.entry_kept      = kept_q;
	assign res.is_current      = current_q;

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// self-checking testbench of the ratio test stereo matcher
module tb_top;
	import rtsm_pkg::*;

	localparam int DIST_TOP      = 256;
	localparam int CMD_CODE_LAST = (1 << CMD_W) - 1;
	localparam int IDLE_MAX      = 11;
	localparam int DRAIN_CYCLES  = 8;
	localparam int LONG_HOLD     = 300;
	localparam int PAIR_KEEP     = 32;

	typedef struct packed {
		logic               accepted;
		logic [RIGHT_W-1:0] matched_right;
		logic [DIST_W-1:0]  best_distance;
		logic [DIST_W-1:0]  second_distance;
		logic               entry_kept;
		logic               is_current;
	} answer_t;

	typedef struct packed {
		logic [RIGHT_W-1:0] right;
		logic [LEFT_W-1:0]  left;
	} pair_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	rtsm_in_if cmd_ch ();
	rtsm_out_if res_ch ();

	ratio_test_stereo_matcher i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_ch),
		.res       (res_ch)
	);

	// matcher state as predicted
	logic [CFG_W-1:0]   cfg_max_best = MAX_BEST_RESET;
	logic [CFG_W-1:0]   cfg_bypass   = BYPASS_RESET;
	logic [CFG_W-1:0]   cfg_ratio    = RATIO_RESET;
	logic [DIST_W-1:0]  acc_best       = NONE_DIST;
	logic [DIST_W-1:0]  acc_second     = NONE_DIST;
	logic [RIGHT_W-1:0] acc_best_right = '0;
	bit                 acc_found      = 1'b0;
	logic [DIST_W-1:0]  entry_dist  [RIGHT_ENTRIES];
	logic [LEFT_W-1:0]  entry_owner [RIGHT_ENTRIES];
	bit                 entry_valid [RIGHT_ENTRIES];

	answer_t pending_answers[$];
	pair_t   committed_pairs[$];
	int      mismatch_count = 0;
	int      answer_count   = 0;
	int      sent_items     = 0;
	int      receiver_hold  = 0;
	bit      sender_idle    = 1'b1;
	bit      receiver_idle  = 1'b1;

	initial begin
		clk = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.command = '0;
		cmd_ch.left_index = '0;
		cmd_ch.right_index = '0;
		cmd_ch.distance = '0;
		cmd_ch.pair_ok = 1'b0;
		res_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_MAX_BEST;
		cfg_data = '0;
		foreach (entry_valid[i]) entry_valid[i] = 1'b0;
	end

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic bit predict_matcher(input logic [CMD_W-1:0] command,
		input logic [LEFT_W-1:0] left, input logic [RIGHT_W-1:0] right,
		input logic [DIST_W-1:0] distance, input logic ok, output answer_t answer);
		logic [PROD_W-1:0] product;
		bit in_range;
		bit produces;
		answer = '0;
		produces = 1'b0;
		in_range = (int'(right) < RIGHT_ENTRIES) && (int'(left) < LEFT_ENTRIES);
		case (command)
			CMD_CANDIDATE: begin
				if (ok) begin
					if (distance < acc_best) begin
						acc_second = acc_best;
						acc_best = distance;
						acc_best_right = right;
						acc_found = 1'b1;
					end else if (distance < acc_second) begin
						acc_second = distance;
					end
				end
			end
			CMD_DECIDE: begin
				product = cfg_ratio * acc_second;
				answer.accepted = acc_found && (acc_best <= cfg_max_best)
					&& ((acc_second >= cfg_bypass) || (acc_best <= (product >> 8)));
				answer.matched_right = acc_best_right;
				answer.best_distance = acc_best;
				answer.second_distance = acc_second;
				acc_best = NONE_DIST;
				acc_second = NONE_DIST;
				acc_best_right = '0;
				acc_found = 1'b0;
				produces = 1'b1;
			end
			CMD_COMMIT: begin
				if (in_range && (!entry_valid[right] || distance < entry_dist[right])) begin
					entry_valid[right] = 1'b1;
					entry_dist[right] = distance;
					entry_owner[right] = left;
					answer.entry_kept = 1'b1;
				end
				produces = 1'b1;
			end
			CMD_QUERY: begin
				answer.is_current = in_range && entry_valid[right] && entry_owner[right] == left;
				produces = 1'b1;
			end
			CMD_CLEAR: begin
				foreach (entry_valid[i]) entry_valid[i] = 1'b0;
			end
			default: ;
		endcase
		return produces;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
		input logic [15:0] want);
		$display("t=%0t answer %0d %s: got %0h, want %0h", $time, answer_count, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_field(input string what, input logic [15:0] got, input logic [15:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	always @(posedge clk) begin
		answer_t want;
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (pending_answers.size() == 0) begin
				report_mismatch("unexpected answer", '0, '0);
			end else begin
				want = pending_answers.pop_front();
				check_field("accepted", 16'(res_ch.accepted), 16'(want.accepted));
				check_field("matched_right", 16'(res_ch.matched_right),
					16'(want.matched_right));
				check_field("best_distance", 16'(res_ch.best_distance),
					16'(want.best_distance));
				check_field("second_distance", 16'(res_ch.second_distance),
					16'(want.second_distance));
				check_field("entry_kept", 16'(res_ch.entry_kept), 16'(want.entry_kept));
				check_field("is_current", 16'(res_ch.is_current), 16'(want.is_current));
			end
			answer_count++;
		end
	end

	// answer side: random stalls, one long hold when asked
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			gap = receiver_idle ? $urandom_range(0, IDLE_MAX) : 0;
			if (receiver_hold > 0) begin
				gap = receiver_hold;
				receiver_hold = 0;
			end
			@(negedge clk);
			if (gap > 0) begin
				res_ch.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			res_ch.ready = 1'b1;
			do @(posedge clk); while (res_ch.valid !== 1'b1);
		end
	end

	task automatic send_request(input logic [CMD_W-1:0] command, input logic [LEFT_W-1:0] left,
		input logic [RIGHT_W-1:0] right, input logic [DIST_W-1:0] distance, input logic ok);
		int gap;
		answer_t answer;
		gap = sender_idle ? $urandom_range(0, IDLE_MAX) : 0;
		@(negedge clk);
		if (gap > 0) begin
			cmd_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.command = command;
		cmd_ch.left_index = left;
		cmd_ch.right_index = right;
		cmd_ch.distance = distance;
		cmd_ch.pair_ok = ok;
		cmd_ch.valid = 1'b1;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		sent_items++;
		if (predict_matcher(command, left, right, distance, ok, answer))
			pending_answers = {pending_answers, answer};
	endtask

	task automatic settle_block();
		@(negedge clk);
		cmd_ch.valid = 1'b0;
		while (pending_answers.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic apply_config(input logic [CFG_W-1:0] max_best, input logic [CFG_W-1:0] bypass,
		input logic [CFG_W-1:0] ratio);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = REG_MAX_BEST;
		cfg_data = max_best;
		@(negedge clk);
		cfg_index = REG_BYPASS;
		cfg_data = bypass;
		@(negedge clk);
		cfg_index = REG_RATIO;
		cfg_data = ratio;
		@(negedge clk);
		cfg_we = 1'b0;
		cfg_max_best = max_best;
		cfg_bypass = bypass;
		cfg_ratio = ratio;
	endtask

	function automatic logic [RIGHT_W-1:0] pick_right();
		if ($urandom_range(0, 1))
			return RIGHT_W'($urandom_range(0, 15));
		return RIGHT_W'($urandom_range(0, RIGHT_ENTRIES - 1));
	endfunction

	// mostly near the thresholds, sometimes the extremes and the none mark
	function automatic logic [DIST_W-1:0] draw_distance();
		int top;
		top = int'(cfg_max_best) + int'(cfg_bypass);
		if (top > DIST_TOP) top = DIST_TOP;
		if (top < 1) top = 1;
		case ($urandom_range(0, 15))
			0: return '0;
			1: return DIST_W'(DIST_TOP);
			2: return NONE_DIST;
			3: return DIST_W'($urandom_range(DIST_TOP + 1, int'(NONE_DIST)));
			default: return DIST_W'($urandom_range(0, top));
		endcase
	endfunction

	function automatic logic [LEFT_W-1:0] pick_left();
		return LEFT_W'($urandom_range(0, LEFT_ENTRIES - 1));
	endfunction

	task automatic send_left_feature();
		int n;
		pair_t pair;
		n = $urandom_range(0, 10);
		repeat (n)
			send_request(CMD_CANDIDATE, pick_left(), pick_right(), draw_distance(),
				$urandom_range(0, 7) != 0);
		send_request(CMD_DECIDE, pick_left(), pick_right(), draw_distance(),
			1'($urandom_range(0, 1)));
		if ($urandom_range(0, 1)) begin
			pair.left = pick_left();
			pair.right = pick_right();
			send_request(CMD_COMMIT, pair.left, pair.right, draw_distance(),
				1'($urandom_range(0, 1)));
			committed_pairs = {committed_pairs, pair};
			if (committed_pairs.size() > PAIR_KEEP)
				void'(committed_pairs.pop_front());
		end
		if ($urandom_range(0, 1) && committed_pairs.size() > 0) begin
			pair = committed_pairs[$urandom_range(0, committed_pairs.size() - 1)];
			send_request(CMD_QUERY, pair.left, pair.right, draw_distance(),
				1'($urandom_range(0, 1)));
		end
	endtask

	task automatic test_directed_cases();
		send_request(CMD_DECIDE, '0, '0, '0, 1'b0);
		send_request(CMD_CANDIDATE, '0, 10'd5, '0, 1'b0);
		send_request(CMD_CANDIDATE, '1, 10'd6, NONE_DIST, 1'b1);
		send_request(CMD_DECIDE, '1, '1, '1, 1'b1);
		// equal minima: first keeps the index, second takes the same distance
		send_request(CMD_CANDIDATE, '0, '1, 9'd30, 1'b1);
		send_request(CMD_CANDIDATE, '0, 10'd7, 9'd30, 1'b1);
		send_request(CMD_DECIDE, '0, '0, '0, 1'b0);
		send_request(CMD_CANDIDATE, '0, 10'd3, 9'd40, 1'b1);
		send_request(CMD_CANDIDATE, '0, 10'd9, 9'd100, 1'b1);
		send_request(CMD_DECIDE, '0, '0, '0, 1'b0);
		send_request(CMD_CANDIDATE, '0, 10'd1, 9'd256, 1'b1);
		send_request(CMD_CANDIDATE, '0, '0, '0, 1'b1);
		send_request(CMD_DECIDE, '0, '0, '0, 1'b0);
		send_request(CMD_CANDIDATE, '0, 10'd2, 9'd200, 1'b1);
		send_request(CMD_CANDIDATE, '0, 10'd4, 9'd61, 1'b1);
		send_request(CMD_DECIDE, '0, '0, '0, 1'b0);
		send_request(CMD_COMMIT, '1, '1, 9'd256, 1'b0);
		send_request(CMD_COMMIT, '0, '1, 9'd256, 1'b1);
		send_request(CMD_COMMIT, 12'd1, '1, '0, 1'b0);
		send_request(CMD_QUERY, 12'd1, '1, '0, 1'b0);
		send_request(CMD_QUERY, '1, '1, '0, 1'b0);
		send_request(CMD_CLEAR, '1, '1, '1, 1'b1);
		send_request(CMD_QUERY, 12'd1, '1, '0, 1'b0);
		send_request(CMD_COMMIT, 12'd2, '1, NONE_DIST, 1'b1);
		for (int code = int'(CMD_CLEAR) + 1; code <= CMD_CODE_LAST; code++)
			send_request(CMD_W'(code), '1, '1, '1, 1'b1);
	endtask

	task automatic test_ratio_settings();
		logic [CFG_W-1:0] settings [6][3] = '{
			'{9'd60, 9'd80, 9'd218},
			'{9'd1, 9'd1, 9'd26},
			'{9'd256, 9'd256, 9'd256},
			'{9'd256, 9'd1, 9'd26},
			'{9'd1, 9'd256, 9'd256},
			'{9'd128, 9'd100, 9'd128}
		};
		int stop_at;
		for (int s = 0; s < 6; s++) begin
			settle_block();
			apply_config(settings[s][0], settings[s][1], settings[s][2]);
			sender_idle = (s % 3) != 2;
			receiver_idle = (s % 2) == 0;
			stop_at = sent_items + 150;
			while (sent_items < stop_at)
				send_left_feature();
		end
		sender_idle = 1'b1;
		receiver_idle = 1'b1;
	endtask

	task automatic test_backpressure();
		logic [CMD_W-1:0] command;
		settle_block();
		sender_idle = 1'b0;
		receiver_hold = LONG_HOLD;
		repeat (80) begin
			case ($urandom_range(0, 3))
				0: command = CMD_CANDIDATE;
				1: command = CMD_DECIDE;
				2: command = CMD_COMMIT;
				default: command = CMD_QUERY;
			endcase
			send_request(command, pick_left(), pick_right(), draw_distance(), 1'b1);
		end
		settle_block();
		sender_idle = 1'b1;
	endtask

	// enough clears to wrap the clear epoch, with commits and queries between
	task automatic test_clear_epochs();
		pair_t last_pair;
		pair_t pair;
		last_pair = '0;
		receiver_idle = 1'b0;
		for (int i = 0; i < 260; i++) begin
			send_request(CMD_CLEAR, pick_left(), pick_right(), draw_distance(),
				1'($urandom_range(0, 1)));
			if (i % 4 == 0) begin
				pair.right = RIGHT_W'(i % 64);
				pair.left = LEFT_W'(i * 13);
				send_request(CMD_QUERY, last_pair.left, last_pair.right, '0, 1'b0);
				send_request(CMD_COMMIT, pair.left, pair.right, draw_distance(), 1'b1);
				send_request(CMD_QUERY, pair.left, pair.right, '0, 1'b0);
				last_pair = pair;
			end
		end
		receiver_idle = 1'b1;
	endtask

	task automatic test_random_noise();
		logic [CFG_W-1:0] settings [2][3] = '{
			'{9'd511, 9'd0, 9'd511},
			'{9'd0, 9'd511, 9'd0}
		};
		for (int s = 0; s < 2; s++) begin
			settle_block();
			apply_config(settings[s][0], settings[s][1], settings[s][2]);
			repeat (150)
				send_request(CMD_W'($urandom_range(0, CMD_CODE_LAST)), pick_left(),
					RIGHT_W'($urandom_range(0, RIGHT_ENTRIES - 1)),
					DIST_W'($urandom_range(0, int'(NONE_DIST))),
					1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		#1000000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		test_directed_cases();
		test_ratio_settings();
		test_backpressure();
		test_clear_epochs();
		test_random_noise();
		settle_block();
		repeat (20) @(negedge clk);
		if (mismatch_count == 0 && pending_answers.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
